>>> hw/rtl/frlw_pkg.sv
// ----------------------------------------------------------------------------
// frlw_pkg
// Shared types, constants and helpers of the flash ring log writer.
// ----------------------------------------------------------------------------
package frlw_pkg;

   // Default build values
   localparam int unsigned DEF_CHANNELS     = 10;
   localparam int unsigned DEF_SECTOR_BYTES = 4096;
   localparam int unsigned DEF_MAX_SECTORS  = 4096;

   // Fixed field widths
   localparam int unsigned MAX_CH     = 10;
   localparam int unsigned TEMP_W     = 16;
   localparam int unsigned ADDR_W     = 24;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned CFG_W      = 13;
   localparam int unsigned CMP_W      = CFG_W + 1;
   localparam int unsigned REC_BYTES  = 32;
   localparam int unsigned REC_BITS   = REC_BYTES * 8;
   localparam int unsigned HDR_BYTES  = 64;
   localparam int unsigned BYTE_CNT_W = 5;

   // Header words
   localparam logic [WORD_W-1:0] HDR_MAGIC   = 32'h5345_4354;
   localparam logic [WORD_W-1:0] HDR_VERSION = 32'h0000_0003;
   localparam logic [WORD_W-1:0] FILL_WORD   = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] CRC_INIT    = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] CRC_POLY    = 32'hEDB8_8320;

   // Configuration
   localparam logic [CFG_W-1:0] CFG_RESET        = 13'd16;
   localparam logic             REG_SECTOR_COUNT = 1'b0;

   // Flash commands
   localparam logic CMD_ERASE   = 1'b0;
   localparam logic CMD_PROGRAM = 1'b1;

   // Command index within one item: erase, header words, magic, record words, sequence
   localparam int unsigned  IDX_W         = 5;
   localparam logic [4:0]   IDX_ERASE     = 5'd0;
   localparam logic [4:0]   IDX_VERSION   = 5'd1;
   localparam logic [4:0]   IDX_START_SEQ = 5'd2;
   localparam logic [4:0]   IDX_HDR_CRC   = 5'd3;
   localparam logic [4:0]   IDX_MAGIC     = 5'd16;
   localparam logic [4:0]   IDX_REC_FIRST = 5'd17;
   localparam logic [4:0]   IDX_SEQ       = 5'd24;

   // Job queue
   localparam int unsigned FIFO_DEPTH = 2;

   typedef struct packed {
      logic                change;
      logic [ADDR_W-1:0]   base;
      logic [ADDR_W-1:0]   off;
      logic [WORD_W-1:0]   hdr_crc;
      logic [REC_BITS-1:0] rec;
   } frlw_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } frlw_fifo_status_type;

   // Lay out a record with 0xFF fill; the CRC is placed later
   function automatic logic [REC_BITS-1:0] build_record(
      input logic [WORD_W-1:0]        seq,
      input logic [WORD_W-1:0]        stamp,
      input logic [MAX_CH*TEMP_W-1:0] temps,
      input int unsigned              channels
   );
      logic [REC_BITS-1:0] rec;
      rec          = '1;
      rec[31:0]    = seq;
      rec[63:32]   = stamp;
      for (int i = 0; i < MAX_CH; i++) begin
         if (i < channels) begin
            rec[64 + TEMP_W*i +: TEMP_W] = temps[TEMP_W*i +: TEMP_W];
         end
      end
      return rec;
   endfunction

endpackage

>>> hw/rtl/flash_ring_log_writer.sv
// ----------------------------------------------------------------------------
// flash_ring_log_writer
// Appends timestamped temperature records to a circular flash sector log
// and emits the erase and program commands, with CRC-32 protected headers
// and records.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  timestamp, temp_0..temp_9
//   rsp_      out        rsp_valid/rsp_stall  command, flash_address,
//                                             write_data, last
//   config    in         APB (psel..pready)   sector_count at byte 0
//
// Front: the byte-serial CRC-32 unit covers the header on a sector change,
// then the record; a new item is taken only once the last one is pushed,
// which waits while the queue is full. Back: one command per cycle while a
// job is queued and rsp_stall is low, 8 per item, 25 on a sector change.
// A two-entry job queue and the output register let either side stall alone.
// Reset is synchronous; sector 0 is taken as prepared, sector_count is 16.
// ----------------------------------------------------------------------------
module flash_ring_log_writer #(
   parameter int unsigned CHANNELS     = frlw_pkg::DEF_CHANNELS,
   parameter int unsigned SECTOR_BYTES = frlw_pkg::DEF_SECTOR_BYTES,
   parameter int unsigned MAX_SECTORS  = frlw_pkg::DEF_MAX_SECTORS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [frlw_pkg::WORD_W-1:0]          req_timestamp,
   input  logic signed [frlw_pkg::TEMP_W-1:0]   req_temp_0,
   input  logic signed [frlw_pkg::TEMP_W-1:0]   req_temp_1,
   input  logic signed [frlw_pkg::TEMP_W-1:0]   req_temp_2,
   input  logic signed [frlw_pkg::TEMP_W-1:0]   req_temp_3,
   input  logic signed [frlw_pkg::TEMP_W-1:0]   req_temp_4,
   input  logic signed [frlw_pkg::TEMP_W-1:0]   req_temp_5,
   input  logic signed [frlw_pkg::TEMP_W-1:0]   req_temp_6,
   input  logic signed [frlw_pkg::TEMP_W-1:0]   req_temp_7,
   input  logic signed [frlw_pkg::TEMP_W-1:0]   req_temp_8,
   input  logic signed [frlw_pkg::TEMP_W-1:0]   req_temp_9,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_command,
   output logic [frlw_pkg::ADDR_W-1:0]          rsp_flash_address,
   output logic [frlw_pkg::WORD_W-1:0]          rsp_write_data,
   output logic                                 rsp_last,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import frlw_pkg::*;

   logic [CFG_W-1:0]            sector_count_ff;
   logic                        cfg_write;
   logic [MAX_CH*TEMP_W-1:0]    temps;
   logic                        push;
   logic                        pop;
   frlw_job_type                push_job;
   frlw_job_type                head;
   frlw_fifo_status_type        fifo_status;

   // Configuration register
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_SECTOR_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_count_ff <= CFG_RESET;
      end else if (cfg_write) begin
         sector_count_ff <= pwdata[CFG_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_SECTOR_COUNT) ? 32'(sector_count_ff) : '0;

   // Gather the temperatures as raw bit patterns
   assign temps = {req_temp_9, req_temp_8, req_temp_7, req_temp_6, req_temp_5,
                   req_temp_4, req_temp_3, req_temp_2, req_temp_1, req_temp_0};

   frlw_front #(
      .CHANNELS     (CHANNELS),
      .SECTOR_BYTES (SECTOR_BYTES),
      .MAX_SECTORS  (MAX_SECTORS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_timestamp (req_timestamp),
      .req_temps     (temps),
      .sector_count  (sector_count_ff),
      .fifo_status   (fifo_status),
      .push          (push),
      .job           (push_job)
   );

   frlw_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (fifo_status)
   );

   frlw_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .fifo_status       (fifo_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command       (rsp_command),
      .rsp_flash_address (rsp_flash_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_last          (rsp_last)
   );

endmodule

>>> hw/rtl/frlw_crc.sv
// ----------------------------------------------------------------------------
// frlw_crc
// Reflected CRC-32, one byte per cycle while byte_valid is high.
// ----------------------------------------------------------------------------
module frlw_crc (
   input  logic                          clock,
   input  logic                          byte_valid,
   input  logic                          start,
   input  logic [7:0]                    data,
   output logic [frlw_pkg::WORD_W-1:0]   crc
);
   import frlw_pkg::*;

   logic [WORD_W-1:0] crc_ff;
   logic [WORD_W-1:0] crc_in;

   // Fold one byte into the running value, restarting on start
   always_comb begin
      crc_in = start ? CRC_INIT : crc_ff;
      crc_in = crc_in ^ {24'h000000, data};
      for (int b = 0; b < 8; b++) begin
         crc_in = crc_in[0] ? ((crc_in >> 1) ^ CRC_POLY) : (crc_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (byte_valid) begin
         crc_ff <= crc_in;
      end
   end

   assign crc = ~crc_ff;

endmodule

>>> hw/rtl/frlw_front.sv
// ----------------------------------------------------------------------------
// frlw_front
// Accepts records, advances the sector and slot, computes the record CRC and,
// on a sector change, the header CRC, and hands a finished job to the queue.
// ----------------------------------------------------------------------------
module frlw_front #(
   parameter int unsigned CHANNELS     = frlw_pkg::DEF_CHANNELS,
   parameter int unsigned SECTOR_BYTES = frlw_pkg::DEF_SECTOR_BYTES,
   parameter int unsigned MAX_SECTORS  = frlw_pkg::DEF_MAX_SECTORS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_stall,
   input  logic [frlw_pkg::WORD_W-1:0]                   req_timestamp,
   input  logic [frlw_pkg::MAX_CH*frlw_pkg::TEMP_W-1:0]  req_temps,
   input  logic [frlw_pkg::CFG_W-1:0]                    sector_count,
   input  frlw_pkg::frlw_fifo_status_type                fifo_status,
   output logic                                          push,
   output frlw_pkg::frlw_job_type                        job
);
   import frlw_pkg::*;

   localparam int unsigned SW      = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
   localparam int unsigned SBW     = $clog2(SECTOR_BYTES + 1);
   localparam int unsigned SLOTS   = (SECTOR_BYTES - HDR_BYTES) / REC_BYTES;
   localparam int unsigned SLOT_W  = $clog2(SLOTS + 1);
   localparam int unsigned CRC_LEN = 8 + 2 * CHANNELS;

   typedef enum logic [4:0] {
      F_IDLE = 5'b00001,
      F_ADDR = 5'b00010,
      F_HCRC = 5'b00100,
      F_RCRC = 5'b01000,
      F_PUSH = 5'b10000
   } front_state_type;

   front_state_type         state_ff, state_in;
   logic [BYTE_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SW-1:0]           sector_ff, sector_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [SLOT_W-1:0]       slot_use_ff;
   logic [WORD_W-1:0]       seq_ff, seq_in;
   logic                    change_ff;
   logic [REC_BITS-1:0]     rec_ff;
   logic [ADDR_W-1:0]       base_ff;
   logic [WORD_W-1:0]       hcrc_ff;

   logic                    accept;
   logic                    change;
   logic [SW:0]             next_wide;
   logic [CFG_W-1:0]        eff_count;
   logic [SW-1:0]           next_sector;
   logic [SW+SBW-1:0]       product;
   logic [63:0]             hdr_bytes;
   logic                    crc_valid;
   logic                    crc_start;
   logic [7:0]              crc_byte;
   logic [WORD_W-1:0]       crc;

   assign req_stall = (state_ff != F_IDLE);
   assign accept    = req_valid && !req_stall;

   // Clamp the configured count and find the next sector with wrap
   always_comb begin
      priority if (sector_count == '0) begin
         eff_count = CFG_W'(1);
      end else if (sector_count > CFG_W'(MAX_SECTORS)) begin
         eff_count = CFG_W'(MAX_SECTORS);
      end else begin
         eff_count = sector_count;
      end
      next_wide   = {1'b0, sector_ff} + 1'b1;
      next_sector = (CMP_W'(next_wide) >= CMP_W'(eff_count)) ? '0 : next_wide[SW-1:0];
      change      = (slot_ff >= SLOT_W'(SLOTS));
   end

   // Sector base address
   assign product = SW'(sector_ff) * SBW'(SECTOR_BYTES);

   // Header bytes covered by the header CRC: version, then start sequence
   assign hdr_bytes = {rec_ff[31:0], HDR_VERSION};

   // Feed the CRC unit from the header or the record
   always_comb begin
      crc_valid = (state_ff == F_HCRC) || (state_ff == F_RCRC);
      crc_start = (cnt_ff == '0);
      crc_byte  = (state_ff == F_HCRC) ? hdr_bytes[8*cnt_ff[2:0] +: 8]
                                       : rec_ff[8*cnt_ff +: 8];
   end

   frlw_crc u_crc (
      .clock      (clock),
      .byte_valid (crc_valid),
      .start      (crc_start),
      .data       (crc_byte),
      .crc        (crc)
   );

   // Sequence the item through address, header CRC, record CRC and hand-off
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      sector_in = sector_ff;
      slot_in   = slot_ff;
      seq_in    = seq_ff;
      push      = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               sector_in = change ? next_sector : sector_ff;
               slot_in   = change ? SLOT_W'(1) : SLOT_W'(slot_ff + 1'b1);
               seq_in    = seq_ff + 1'b1;
               state_in  = F_ADDR;
            end
         end
         F_ADDR: begin
            cnt_in   = '0;
            state_in = change_ff ? F_HCRC : F_RCRC;
         end
         F_HCRC: begin
            if (cnt_ff == BYTE_CNT_W'(7)) begin
               cnt_in   = '0;
               state_in = F_RCRC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         F_RCRC: begin
            if (cnt_ff == BYTE_CNT_W'(CRC_LEN - 1)) begin
               state_in = F_PUSH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         F_PUSH: begin
            if (!fifo_status.full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // Control and log position
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         cnt_ff    <= '0;
         sector_ff <= '0;
         slot_ff   <= '0;
         seq_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         sector_ff <= sector_in;
         slot_ff   <= slot_in;
         seq_ff    <= seq_in;
      end
   end

   // Item payload
   always_ff @(posedge clock) begin
      if (accept) begin
         change_ff   <= change;
         slot_use_ff <= change ? '0 : slot_ff;
         rec_ff      <= build_record(seq_in, req_timestamp, req_temps, CHANNELS);
      end
      if (state_ff == F_ADDR) begin
         base_ff <= ADDR_W'(product);
      end
      // header CRC is complete when the record pass starts
      if ((state_ff == F_RCRC) && (cnt_ff == '0)) begin
         hcrc_ff <= crc;
      end
   end

   // Assemble the job with the record CRC in place
   always_comb begin
      job                            = '0;
      job.change                     = change_ff;
      job.base                       = base_ff;
      job.off                        = base_ff + ADDR_W'(HDR_BYTES)
                                       + (ADDR_W'(slot_use_ff) << 5);
      job.hdr_crc                    = hcrc_ff;
      job.rec                        = rec_ff;
      job.rec[CRC_LEN*8 +: WORD_W]   = crc;
   end

   // A sector change always lands on the first slot
   a_slot_after_change: assert property (@(posedge clock) disable iff (reset)
      accept && change |=> slot_ff == SLOT_W'(1))
      else $error("slot not restarted after sector change");

endmodule

>>> hw/rtl/frlw_fifo.sv
// ----------------------------------------------------------------------------
// frlw_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module frlw_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  frlw_pkg::frlw_job_type           push_job,
   input  logic                             pop,
   output frlw_pkg::frlw_job_type           head,
   output frlw_pkg::frlw_fifo_status_type   status
);
   import frlw_pkg::*;

   localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

   frlw_job_type       entries_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign status.full  = (count_ff == (PTR_W+1)'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entries_ff[rd_ptr_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("job pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("job popped from empty queue");

endmodule

>>> hw/rtl/frlw_back.sv
// ----------------------------------------------------------------------------
// frlw_back
// Walks one job through its flash commands into the output register.
// ----------------------------------------------------------------------------
module frlw_back (
   input  logic                             clock,
   input  logic                             reset,
   input  frlw_pkg::frlw_job_type           head,
   input  frlw_pkg::frlw_fifo_status_type   fifo_status,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_command,
   output logic [frlw_pkg::ADDR_W-1:0]      rsp_flash_address,
   output logic [frlw_pkg::WORD_W-1:0]      rsp_write_data,
   output logic                             rsp_last
);
   import frlw_pkg::*;

   logic                started_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                rsp_valid_ff;
   logic                rsp_command_ff, rsp_command_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [WORD_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff;

   logic                advance;
   logic                emit;
   logic [IDX_W-1:0]    cur_idx;
   logic [2:0]          rec_w;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign emit    = advance && !fifo_status.empty;
   assign cur_idx = started_ff ? idx_ff : (head.change ? IDX_ERASE : IDX_REC_FIRST);
   assign pop     = emit && (cur_idx == IDX_SEQ);
   // record word: 1..7 for the body, wraps to 0 for the sequence word
   assign rec_w   = 3'(cur_idx - IDX_MAGIC);

   // Select the command for the current index
   always_comb begin
      rsp_command_in = CMD_PROGRAM;
      rsp_addr_in    = head.base + ADDR_W'({cur_idx[3:0], 2'b00});
      rsp_data_in    = FILL_WORD;
      priority if (cur_idx == IDX_ERASE) begin
         rsp_command_in = CMD_ERASE;
         rsp_data_in    = '0;
      end else if (cur_idx == IDX_VERSION) begin
         rsp_data_in = HDR_VERSION;
      end else if (cur_idx == IDX_START_SEQ) begin
         rsp_data_in = head.rec[31:0];
      end else if (cur_idx == IDX_HDR_CRC) begin
         rsp_data_in = head.hdr_crc;
      end else if (cur_idx < IDX_MAGIC) begin
         rsp_data_in = FILL_WORD;
      end else if (cur_idx == IDX_MAGIC) begin
         rsp_addr_in = head.base;
         rsp_data_in = HDR_MAGIC;
      end else begin
         rsp_addr_in = head.off + ADDR_W'({rec_w, 2'b00});
         rsp_data_in = head.rec[WORD_W*rec_w +: WORD_W];
      end
   end

   // Step through the job and fill the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         idx_ff       <= IDX_ERASE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= !fifo_status.empty;
         end
         if (emit) begin
            started_ff <= !pop;
            idx_ff     <= cur_idx + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_command_ff <= rsp_command_in;
         rsp_addr_ff    <= rsp_addr_in;
         rsp_data_ff    <= rsp_data_in;
         rsp_last_ff    <= pop;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command       = rsp_command_ff;
   assign rsp_flash_address = rsp_addr_ff;
   assign rsp_write_data    = rsp_data_ff;
   assign rsp_last          = rsp_last_ff;

   a_last_is_program: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_command == CMD_PROGRAM)
      else $error("final command of an item is not a program");

   a_erase_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == CMD_ERASE) |-> rsp_write_data == '0 && !rsp_last)
      else $error("erase carries data or ends an item");

endmodule
